// ===== src/lmcr_pkg.sv =====
package lmcr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFRESH,
    ST_INIT
  } state_e;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_REFRESH = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;

  // Driver chip register addresses.
  localparam logic [7:0] REG_SCAN_LIMIT = 8'h0b;
  localparam logic [7:0] REG_DECODE     = 8'h09;
  localparam logic [7:0] REG_SHUTDOWN   = 8'h0c;
  localparam logic [7:0] REG_TEST       = 8'h0f;
  localparam logic [7:0] REG_INTENSITY  = 8'h0a;

  localparam logic [7:0] SCAN_ALL_DIGITS = 8'h07;
  localparam logic [7:0] NO_DECODE       = 8'h00;
  localparam logic [7:0] NORMAL_OP       = 8'h01;
  localparam logic [7:0] TEST_OFF        = 8'h00;
  localparam logic [7:0] INTENSITY_RESET = 8'hff;

  localparam logic [5:0] REFRESH_LAST = 6'd31;
  localparam logic [5:0] INIT_LAST    = 6'd51;

  typedef struct packed {
    logic [15:0] frame_word;
    logic [1:0]  chain_slot;
    logic        latch;
    logic        last;
  } out_item_t;

  // Word broadcast by one init group: five setup registers, then eight
  // digit registers cleared to zero.
  function automatic logic [15:0] init_word(logic [3:0] grp, logic [7:0] intensity);
    logic [3:0]  digit;
    logic [15:0] word;
    digit = grp - 4'd4;
    unique case (grp)
      4'd0:    word = {REG_SCAN_LIMIT, SCAN_ALL_DIGITS};
      4'd1:    word = {REG_DECODE, NO_DECODE};
      4'd2:    word = {REG_SHUTDOWN, NORMAL_OP};
      4'd3:    word = {REG_TEST, TEST_OFF};
      4'd4:    word = {REG_INTENSITY, intensity};
      default: word = {4'h0, digit, 8'h00};
    endcase
    return word;
  endfunction

endpackage

// ===== src/led_matrix_chain_refresher.sv =====
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i / in_stall_o  opcode_i, row_index_i, row_bits_i
// output    out        out_valid_o / out_stall_i frame_word_o, chain_slot_o, latch_o, last_o
// config    in         cfg_we_i                 cfg_wdata_i (intensity)
//
// A row write goes to the frame store as it is accepted. A refresh first fetches
// the first row, then gives one word per cycle while the output does not stall,
// set by the single read port of the frame store feeding one output register.
// Reset clears the sequencer, the output valid bit and the row valid bits;
// rows never written read as zero. A stall on the output holds the word and
// pauses the sequencer; the input stalls while a command is running.

module led_matrix_chain_refresher #(
  parameter int FRAME_ROWS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  row_index_i,
  input  logic [14:0] row_bits_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] frame_word_o,
  output logic [1:0]  chain_slot_o,
  output logic        latch_o,
  output logic        last_o
);

  localparam int AW = $clog2(FRAME_ROWS);

  logic [7:0]          intensity_q;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [14:0]         wr_data, rd_data;
  lmcr_pkg::out_item_t out_item;

  // Brightness byte, sent to the intensity register by the init sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= lmcr_pkg::INTENSITY_RESET;
    end else if (cfg_we_i) begin
      intensity_q <= cfg_wdata_i;
    end
  end

  // The frame store holds one entry per LED row; refresh reads it ahead
  // of each word.
  lmcr_frame_store #(
    .FRAME_ROWS(FRAME_ROWS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // The sequencer walks the 32 refresh words or the 52 init words and
  // presents each through its output register.
  lmcr_sequencer #(
    .FRAME_ROWS(FRAME_ROWS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .row_index_i(row_index_i),
    .row_bits_i (row_bits_i),
    .intensity_i(intensity_q),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item)
  );

  assign frame_word_o = out_item.frame_word;
  assign chain_slot_o = out_item.chain_slot;
  assign latch_o      = out_item.latch;
  assign last_o       = out_item.last;

endmodule

// ===== src/lmcr_frame_store.sv =====
module lmcr_frame_store #(
  parameter int FRAME_ROWS = 16,
  localparam int AW = $clog2(FRAME_ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [14:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [14:0]   rd_data_o
);

  logic [14:0] mem [FRAME_ROWS];
  logic [FRAME_ROWS-1:0] row_valid_q;
  logic [14:0] rd_data_q;
  logic        rd_valid_q;

  // Rows that were never written read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : 15'd0;

endmodule

// ===== src/lmcr_sequencer.sv =====
module lmcr_sequencer #(
  parameter int FRAME_ROWS = 16,
  localparam int AW = $clog2(FRAME_ROWS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [3:0]           row_index_i,
  input  logic [14:0]          row_bits_i,
  input  logic [7:0]           intensity_i,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [14:0]          wr_data_o,
  output logic                 rd_en_o,
  output logic [AW-1:0]        rd_addr_o,
  input  logic [14:0]          rd_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lmcr_pkg::out_item_t  out_item_o
);

  localparam logic [AW-1:0] LAST_ROW = AW'(FRAME_ROWS - 1);

  lmcr_pkg::state_e    state_q, state_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  lmcr_pkg::out_item_t out_item_q, out_item_d;

  logic       accept, load, word_last;
  logic [2:0] col, nxt_col;
  logic [1:0] slot, nxt_slot;
  logic [4:0] nxt_word;
  logic [7:0] hi_part, lo_part, data_byte;

  // Row feeding a refresh word: the row of the column for the first two
  // slots, the mirrored row from the bottom of the frame for the last two.
  function automatic logic [AW-1:0] row_addr(logic [2:0] c, logic [1:0] s);
    logic [AW-1:0] a;
    if (s[1]) begin
      a = LAST_ROW - AW'(c);
    end else if (c == 3'd7) begin
      a = '0;
    end else begin
      a = AW'(c);
    end
    return a;
  endfunction

  assign accept    = in_valid_i && (state_q == lmcr_pkg::ST_IDLE);
  assign load      = (state_q != lmcr_pkg::ST_IDLE) && (!out_valid_q || !out_stall_i);
  assign word_last = ((state_q == lmcr_pkg::ST_REFRESH) && (cnt_q == lmcr_pkg::REFRESH_LAST))
                  || ((state_q == lmcr_pkg::ST_INIT) && (cnt_q == lmcr_pkg::INIT_LAST));

  assign col      = cnt_q[4:2];
  assign slot     = cnt_q[1:0];
  assign nxt_word = cnt_q[4:0] + 5'd1;
  assign nxt_col  = nxt_word[4:2];
  assign nxt_slot = nxt_word[1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lmcr_pkg::ST_IDLE: begin
        if (accept && (opcode_i == lmcr_pkg::OP_REFRESH)) begin
          state_d = lmcr_pkg::ST_REFRESH;
        end else if (accept && (opcode_i == lmcr_pkg::OP_INIT)) begin
          state_d = lmcr_pkg::ST_INIT;
        end
      end
      lmcr_pkg::ST_REFRESH, lmcr_pkg::ST_INIT: begin
        if (load && word_last) begin
          state_d = lmcr_pkg::ST_IDLE;
        end
      end
      default: state_d = lmcr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store accesses, word assembly, counter.
  always_comb begin
    hi_part = rd_data_i[14:7];
    lo_part = {rd_data_i[6:0], 1'b0};
    case (slot)
      2'd0:    data_byte = (col != 3'd7) ? hi_part : 8'h00;
      2'd1:    data_byte = (col != 3'd7) ? lo_part : 8'h00;
      2'd2:    data_byte = (col < 3'd6) ? lo_part : 8'h00;
      default: data_byte = (col < 3'd6) ? hi_part : 8'h00;
    endcase

    out_item_d.chain_slot = slot;
    out_item_d.latch      = (slot == 2'd3);
    out_item_d.last       = word_last;
    if (state_q == lmcr_pkg::ST_INIT) begin
      out_item_d.frame_word = lmcr_pkg::init_word(cnt_q[5:2], intensity_i);
    end else begin
      out_item_d.frame_word = {8'(col) + 8'd1, data_byte};
    end

    wr_en_o   = accept && (opcode_i == lmcr_pkg::OP_WRITE)
             && (32'(row_index_i) < 32'(FRAME_ROWS));
    wr_addr_o = AW'(row_index_i);
    wr_data_o = row_bits_i;

    // The read for the next word is issued together with the current one,
    // so the store data is ready when the output register frees up.
    rd_en_o   = (accept && (opcode_i == lmcr_pkg::OP_REFRESH))
             || ((state_q == lmcr_pkg::ST_REFRESH) && load);
    rd_addr_o = (state_q == lmcr_pkg::ST_IDLE) ? '0 : row_addr(nxt_col, nxt_slot);

    if (state_q == lmcr_pkg::ST_IDLE || (load && word_last)) begin
      cnt_d = '0;
    end else if (load) begin
      cnt_d = cnt_q + 6'd1;
    end else begin
      cnt_d = cnt_q;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmcr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= out_item_d;
    end
  end

  assign in_stall_o  = (state_q != lmcr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/lmcr_checker.sv =====
module lmcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  opcode_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] frame_word_o,
  input logic [1:0]  chain_slot_o,
  input logic        latch_o,
  input logic        last_o
);

  // A stalled word stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_word_o)
      && $stable(chain_slot_o) && $stable(last_o))
    else $error("stalled output word changed");

  // The load line pulses only on the fourth word of a group, and every
  // command ends on a complete group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (latch_o == (chain_slot_o == 2'd3)) && (!last_o || latch_o))
    else $error("latch or last on the wrong chain slot");

  // While a word other than the final one is pending, the command is
  // still running and no new item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a command");

  // An accepted refresh keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == lmcr_pkg::OP_REFRESH) |=> in_stall_o)
    else $error("refresh did not start");

endmodule

bind led_matrix_chain_refresher lmcr_checker u_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the LED matrix chain refresher. Commands (row writes,
// refreshes, init sequences and the unused opcode) are queued per phase by the
// stimulus process. A clocked driver offers them on the input channel. A clocked
// monitor compares every output word against a private model of the frame
// store and the intensity register.
module testbench;

  // The fourth opcode value has no meaning in the block and must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned FRAME_DEPTH = 16;
  // A row write gives no word, so the bench waits this long after the last
  // word before it writes the register.
  localparam int unsigned IDLE_SETTLE = 60;
  // The receiver holds off once, after this many commands have gone in.
  localparam int unsigned HOLD_MARK   = 45;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  opcode;
    logic [3:0]  row_index;
    logic [14:0] row_bits;
    int unsigned gap;
  } row_cmd_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i    = lmcr_pkg::OP_WRITE;
  logic [3:0]  row_index_i = '0;
  logic [14:0] row_bits_i  = '0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] frame_word_o;
  logic [1:0]  chain_slot_o;
  logic        latch_o;
  logic        last_o;

  // Private copy of the block's state and the words it still owes us.
  logic [14:0] frame_copy [FRAME_DEPTH] = '{default: '0};
  logic [7:0]  intensity_copy = lmcr_pkg::INTENSITY_RESET;
  lmcr_pkg::out_item_t expected_words [$];

  row_cmd_t    cmd_queue [$];
  row_cmd_t    next_cmd;
  int unsigned offer_wait;
  int unsigned accepted_cmds;

  bit          sender_calm   = 1'b0;
  bit          receiver_calm = 1'b0;
  int unsigned stall_left;
  int unsigned stall_draw;
  logic        long_hold;
  int unsigned hold_count;
  bit          hold_done;

  lmcr_pkg::out_item_t want;
  lmcr_pkg::out_item_t got;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  led_matrix_chain_refresher #(
    .FRAME_ROWS(FRAME_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_word_o(frame_word_o),
    .chain_slot_o(chain_slot_o),
    .latch_o     (latch_o),
    .last_o      (last_o)
  );

  always #4 clk_i = ~clk_i;

  // One output word. Slot 3 closes a chain group and pulses the load line.
  function automatic void push_word(logic [15:0] word, logic [1:0] slot, logic final_word);
    lmcr_pkg::out_item_t item;
    item.frame_word = word;
    item.chain_slot = slot;
    item.latch      = (slot == 2'd3);
    item.last       = final_word;
    expected_words.push_back(item);
  endfunction

  // Updates the frame copy for a row write, or queues the words that a
  // refresh or an init must produce.
  function automatic void predict_chain_words(logic [1:0] op, logic [3:0] row,
                                              logic [14:0] bits);
    logic [14:0] near_row;
    logic [14:0] far_row;
    logic [7:0]  addr;
    logic [15:0] setup [5];
    logic [15:0] word;
    case (op)
      lmcr_pkg::OP_WRITE: begin
        if (row < FRAME_DEPTH) frame_copy[row] = bits;
      end
      lmcr_pkg::OP_REFRESH: begin
        // Digit d = col + 1 takes the top rows from the front of the store
        // and the bottom rows from its back. Digit 8 is blank on every chip,
        // and the back rows stop one digit earlier than the front rows.
        for (int col = 0; col < 8; col++) begin
          near_row = (col < 7) ? frame_copy[col] : '0;
          far_row  = (col < 6) ? frame_copy[FRAME_DEPTH - 1 - col] : '0;
          addr     = 8'(col + 1);
          push_word({addr, near_row[14:7]}, 2'd0, 1'b0);
          push_word({addr, near_row[6:0], 1'b0}, 2'd1, 1'b0);
          push_word({addr, far_row[6:0], 1'b0}, 2'd2, 1'b0);
          push_word({addr, far_row[14:7]}, 2'd3, col == 7);
        end
      end
      lmcr_pkg::OP_INIT: begin
        // Five setup registers, then all eight digit registers cleared. Every
        // chip gets the same word in each group.
        setup[0] = {lmcr_pkg::REG_SCAN_LIMIT, lmcr_pkg::SCAN_ALL_DIGITS};
        setup[1] = {lmcr_pkg::REG_DECODE, lmcr_pkg::NO_DECODE};
        setup[2] = {lmcr_pkg::REG_SHUTDOWN, lmcr_pkg::NORMAL_OP};
        setup[3] = {lmcr_pkg::REG_TEST, lmcr_pkg::TEST_OFF};
        setup[4] = {lmcr_pkg::REG_INTENSITY, intensity_copy};
        for (int grp = 0; grp < 13; grp++) begin
          word = (grp < 5) ? setup[grp] : {8'(grp - 4), 8'h00};
          for (int slot = 0; slot < 4; slot++)
            push_word(word, 2'(slot), grp == 12 && slot == 3);
        end
      end
      default: begin
        // The unused opcode leaves everything alone.
      end
    endcase
  endfunction

  // Driver. A command goes out once its drawn gap has elapsed. While the
  // block stalls, the payload stays put.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      offer_wait    <= 0;
      accepted_cmds <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_chain_words(opcode_i, row_index_i, row_bits_i);
        accepted_cmds <= accepted_cmds + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_queue.size() != 0 && offer_wait >= cmd_queue[0].gap) begin
          next_cmd    = cmd_queue.pop_front();
          in_valid_i  <= 1'b1;
          opcode_i    <= next_cmd.opcode;
          row_index_i <= next_cmd.row_index;
          row_bits_i  <= next_cmd.row_bits;
          offer_wait  <= 0;
        end else begin
          in_valid_i <= 1'b0;
          if (cmd_queue.size() != 0) offer_wait <= offer_wait + 1;
        end
      end
    end
  end

  // Monitor. Each accepted word is checked against the oldest expectation.
  // After each word the receiver draws how long it stalls before the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {frame_word_o, chain_slot_o, latch_o, last_o};
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none, actual word %h slot %0d %s",
                   $time, got.frame_word, got.chain_slot,
                   $sformatf("latch %b last %b", got.latch, got.last));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: expected word %h slot %0d latch %b last %b, %s",
                     $time, want.frame_word, want.chain_slot, want.latch, want.last,
                     $sformatf("actual word %h slot %0d latch %b last %b",
                               got.frame_word, got.chain_slot, got.latch, got.last));
          end
        end
        stall_draw = receiver_calm ? 0 : $urandom_range(0, 3);
      end else begin
        stall_draw = (stall_left == 0) ? 0 : stall_left - 1;
      end
      stall_left  <= stall_draw;
      out_stall_i <= long_hold || (stall_draw != 0);
    end
  end

  // One long hold on the output, counted here. The sender keeps offering
  // commands meanwhile, so the block's sequencer stops and its input stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold  <= 1'b0;
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (!hold_done && accepted_cmds >= HOLD_MARK) begin
      long_hold  <= 1'b1;
      hold_count <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      long_hold  <= (hold_count > 1);
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [3:0] row, logic [14:0] bits);
    row_cmd_t cmd;
    cmd.opcode    = op;
    cmd.row_index = row;
    cmd.row_bits  = bits;
    cmd.gap       = sender_calm ? 0 : $urandom_range(0, 3);
    cmd_queue.push_back(cmd);
  endtask

  // Random commands. Row writes dominate so that refreshes show fresh content.
  // The phase opens with an init so that the current intensity is always seen.
  task automatic queue_random(int unsigned count);
    int unsigned pick;
    logic [1:0]  op;
    logic [14:0] bits;
    queue_cmd(lmcr_pkg::OP_INIT, 4'($urandom_range(0, 15)), 15'($urandom));
    for (int unsigned n = 1; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 52)      op = lmcr_pkg::OP_WRITE;
      else if (pick < 78) op = lmcr_pkg::OP_REFRESH;
      else if (pick < 92) op = lmcr_pkg::OP_INIT;
      else                op = OP_UNUSED;
      pick = $urandom_range(0, 9);
      if (pick == 0)      bits = '1;
      else if (pick == 1) bits = '0;
      else                bits = 15'($urandom);
      queue_cmd(op, 4'($urandom_range(0, 15)), bits);
    end
  endtask

  // Blocks until every queued command has been taken and every word has come
  // back, then lets the block settle.
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  // The register is written only while the block is idle.
  task automatic write_intensity(logic [7:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    intensity_copy = value;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The lowest intensity first. Then a refresh of the cleared store and an init.
    write_intensity(8'h00);
    @(negedge clk_i);
    queue_cmd(lmcr_pkg::OP_REFRESH, 4'd0, 15'd0);
    queue_cmd(lmcr_pkg::OP_INIT, 4'd0, 15'd0);
    // Full rows at both ends of the store, alternating patterns next to the
    // digit limits, and rows that no digit ever shows.
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd0, 15'h7fff);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd15, 15'h7fff);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd6, 15'h5555);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd10, 15'h2aaa);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd7, 15'h7fff);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd8, 15'h7fff);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd9, 15'h7fff);
    queue_cmd(lmcr_pkg::OP_REFRESH, 4'd0, 15'd0);
    // The unused opcode with every field bit set must change nothing.
    queue_cmd(OP_UNUSED, 4'd15, 15'h7fff);
    queue_cmd(lmcr_pkg::OP_REFRESH, 4'd15, 15'h7fff);
    // Patterns on each side of the split between high and low part.
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd0, 15'h0000);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd15, 15'h4001);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd1, 15'h0080);
    queue_cmd(lmcr_pkg::OP_WRITE, 4'd14, 15'h007f);
    queue_cmd(lmcr_pkg::OP_REFRESH, 4'd0, 15'd0);
    queue_cmd(lmcr_pkg::OP_INIT, 4'd0, 15'd0);
    queue_cmd(lmcr_pkg::OP_INIT, 4'd0, 15'd0);
    queue_cmd(OP_UNUSED, 4'd0, 15'd0);
    queue_cmd(lmcr_pkg::OP_REFRESH, 4'd0, 15'd0);

    // The highest intensity. The long output hold falls in this phase.
    write_intensity(8'hff);
    @(negedge clk_i);
    queue_random(65);

    // A stretch with neither side idling.
    write_intensity(8'($urandom_range(1, 254)));
    sender_calm = 1'b1;
    receiver_calm <= 1'b1;
    @(negedge clk_i);
    queue_random(65);

    write_intensity(8'h80);
    sender_calm = 1'b0;
    receiver_calm <= 1'b0;
    @(negedge clk_i);
    queue_random(65);

    write_intensity(8'h01);
    @(negedge clk_i);
    queue_random(65);

    wait_drained();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
